// ===== rtl/core/fragment_table_allocator_defines.svh =====
// Assertion macros for the fragment table allocator
`ifndef FRAGMENT_TABLE_ALLOCATOR_DEFINES_SVH
`define FRAGMENT_TABLE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FTA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fta assertion failed");

// next-cycle implication
`define FTA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fta assertion failed");

`endif

// ===== rtl/core/fta_pkg.sv =====
// Shared types and constants of the fragment table allocator
package fta_pkg;

    localparam int DEF_MAX_FRAGMENTS = 32;
    localparam int DEF_HEADER_BYTES  = 8;
    localparam int DEF_ADDR_BITS     = 32;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        STS_DONE   = 2'd0,
        STS_FULL   = 2'd1,
        STS_BADPTR = 2'd2,
        STS_LIMIT  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MERGE1,
        ST_SEARCH,
        ST_TAKE,
        ST_APPEND,
        ST_APPWR,
        ST_MERGE2,
        ST_FSEARCH,
        ST_FCHECK,
        ST_FHEAD,
        ST_FTAIL,
        ST_FCLR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic        kind;
        t_status     status;
        logic [31:0] user_address;
    } t_rsp;

    localparam int RSP_W = $bits(t_rsp);

endpackage

// ===== rtl/core/fta_queue.sv =====
// Two-entry queue with push/full and pop/empty sides
module fta_queue #(
    parameter int WIDTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    import fta_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/fta_front.sv =====
// Front end: sizes the request and screens the released pointer
module fta_front #(
    parameter int HEADER_BYTES = fta_pkg::DEF_HEADER_BYTES,
    parameter int ADDR_BITS    = fta_pkg::DEF_ADDR_BITS
) (
    input  logic [23:0] i_request_bytes,
    input  logic [31:0] i_address,
    output logic [((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1:0] o_need,
    output logic [((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1:0] o_hdr,
    output logic        o_bad
);
    import fta_pkg::*;

    localparam int SW = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 2;

    assign o_need = SW'(i_request_bytes) + SW'(HEADER_BYTES);
    assign o_hdr  = SW'(i_address) - SW'(HEADER_BYTES);
    assign o_bad  = (i_address == '0) || (SW'(i_address) < SW'(HEADER_BYTES));

endmodule

// ===== rtl/core/fta_back.sv =====
// Back end: fragment table and the merge, search and split sequencer
module fta_back #(
    parameter int MAX_FRAGMENTS = fta_pkg::DEF_MAX_FRAGMENTS,
    parameter int HEADER_BYTES  = fta_pkg::DEF_HEADER_BYTES,
    parameter int ADDR_BITS     = fta_pkg::DEF_ADDR_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_heap_base,
    input  logic [31:0] i_heap_limit,
    input  logic        i_req_valid,
    input  logic        i_req_kind,
    input  logic        i_req_bad,
    input  logic [((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1:0] i_req_need,
    input  logic [((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1:0] i_req_hdr,
    output logic        o_req_pop,
    output fta_pkg::t_rsp o_rsp,
    output logic        o_rsp_valid,
    input  logic        i_rsp_full
);
    import fta_pkg::*;

    localparam int SW = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 2;
    localparam int IW = $clog2(MAX_FRAGMENTS);
    localparam int CW = $clog2(MAX_FRAGMENTS + 1);
    localparam logic [SW-1:0] AMASK = (SW'(1) << ADDR_BITS) - SW'(1);

    logic [ADDR_BITS-1:0] r_start [MAX_FRAGMENTS];
    logic [ADDR_BITS-1:0] r_end   [MAX_FRAGMENTS];
    logic                 r_taken [MAX_FRAGMENTS];

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_i, n_i, rd_idx, i_nxt;
    logic          r_kind, n_kind;
    logic [SW-1:0] r_need, n_need, r_hdr, n_hdr;
    logic [SW-1:0] r_base, n_base, r_fs, n_fs, r_old_end, n_old_end, r_fe, n_fe;
    logic          r_tail, n_tail;
    t_status       r_status, n_status;
    logic [31:0]   r_uaddr, n_uaddr;

    logic [SW-1:0] rd_start, rd_end, sum, base, fe;
    logic          tk_a, tk_b, head, tail;
    logic [CW:0]   slots_tot;

    logic                 op_up, op_dn, op_wb;
    logic                 op_wa_start, op_wa_end, op_wa_taken;
    logic [ADDR_BITS-1:0] wa_start, wa_end, wb_start, wb_end;
    logic                 wa_taken, wb_taken;

    assign i_nxt    = r_i + IW'(1);
    assign rd_start = SW'(r_start[rd_idx]);
    assign rd_end   = SW'(r_end[rd_idx]);
    assign tk_a     = r_taken[r_i];
    assign tk_b     = r_taken[i_nxt];

    assign o_rsp.kind         = r_kind;
    assign o_rsp.status       = r_status;
    assign o_rsp.user_address = r_uaddr;

    always_comb begin
        case (r_state)
            ST_MERGE1, ST_MERGE2: rd_idx = i_nxt;
            ST_APPEND:            rd_idx = IW'(r_count - CW'(1));
            default:              rd_idx = r_i;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_i         = r_i;
        n_kind      = r_kind;
        n_need      = r_need;
        n_hdr       = r_hdr;
        n_base      = r_base;
        n_fs        = r_fs;
        n_old_end   = r_old_end;
        n_fe        = r_fe;
        n_tail      = r_tail;
        n_status    = r_status;
        n_uaddr     = r_uaddr;
        o_req_pop   = 1'b0;
        o_rsp_valid = 1'b0;
        op_up       = 1'b0;
        op_dn       = 1'b0;
        op_wb       = 1'b0;
        op_wa_start = 1'b0;
        op_wa_end   = 1'b0;
        op_wa_taken = 1'b0;
        wa_start    = rd_start[ADDR_BITS-1:0];
        wa_end      = rd_end[ADDR_BITS-1:0];
        wa_taken    = 1'b1;
        wb_start    = '0;
        wb_end      = '0;
        wb_taken    = 1'b1;
        base        = (r_count != '0) ? rd_end : SW'(i_heap_base);
        sum         = base + r_need;
        fe          = (r_need >= r_old_end - r_hdr) ? r_old_end : r_hdr + r_need;
        head        = r_hdr > r_fs;
        tail        = fe < r_old_end;
        slots_tot   = {1'b0, r_count} + (CW+1)'(head) + (CW+1)'(tail);
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_req_pop = 1'b1;
                    n_kind    = i_req_kind;
                    n_need    = i_req_need;
                    n_hdr     = i_req_hdr;
                    n_i       = '0;
                    n_uaddr   = '0;
                    if (i_req_kind == KIND_ALLOC) begin
                        if (r_count >= CW'(MAX_FRAGMENTS)) begin
                            n_status = STS_FULL;
                            n_state  = ST_DONE;
                        end else begin
                            n_state = ST_MERGE1;
                        end
                    end else if (i_req_bad) begin
                        n_status = STS_BADPTR;
                        n_state  = ST_DONE;
                    end else begin
                        n_state = ST_FSEARCH;
                    end
                end
            end
            ST_MERGE1, ST_MERGE2: begin
                if (CW'(r_i) + CW'(1) < r_count) begin
                    if (tk_a == tk_b) begin
                        op_wa_end = 1'b1;
                        op_dn     = 1'b1;
                        n_count   = r_count - CW'(1);
                    end else begin
                        n_i = i_nxt;
                    end
                end else if (r_state == ST_MERGE1) begin
                    n_i     = '0;
                    n_state = ST_SEARCH;
                end else begin
                    n_status = STS_DONE;
                    n_state  = ST_DONE;
                end
            end
            ST_SEARCH: begin
                if (CW'(r_i) < r_count) begin
                    if (!tk_a && (rd_end - rd_start >= r_need)) begin
                        n_state = ST_TAKE;
                    end else if (r_i == IW'(MAX_FRAGMENTS - 1)) begin
                        n_state = ST_APPEND;
                    end else begin
                        n_i = i_nxt;
                    end
                end else begin
                    n_state = ST_APPEND;
                end
            end
            ST_TAKE: begin
                op_wa_taken = 1'b1;
                sum         = rd_start + r_need;
                if (rd_end - rd_start > r_need) begin
                    op_wa_end = 1'b1;
                    wa_end    = sum[ADDR_BITS-1:0];
                    op_wb     = 1'b1;
                    wb_start  = sum[ADDR_BITS-1:0];
                    wb_end    = rd_end[ADDR_BITS-1:0];
                    wb_taken  = 1'b0;
                    op_up     = 1'b1;
                    n_count   = r_count + CW'(1);
                end
                n_base  = rd_start + SW'(HEADER_BYTES);
                n_uaddr = 32'(n_base & AMASK);
                n_i     = '0;
                n_state = ST_MERGE2;
            end
            ST_APPEND: begin
                if (base > AMASK || sum > AMASK || sum > SW'(i_heap_limit)) begin
                    n_status = STS_LIMIT;
                    n_state  = ST_DONE;
                end else begin
                    n_base  = base;
                    n_i     = IW'(r_count);
                    n_state = ST_APPWR;
                end
            end
            ST_APPWR: begin
                sum         = r_base + r_need;
                op_wa_start = 1'b1;
                op_wa_end   = 1'b1;
                op_wa_taken = 1'b1;
                wa_start    = r_base[ADDR_BITS-1:0];
                wa_end      = sum[ADDR_BITS-1:0];
                n_count     = r_count + CW'(1);
                n_base      = r_base + SW'(HEADER_BYTES);
                n_uaddr     = 32'(n_base & AMASK);
                n_i         = '0;
                n_state     = ST_MERGE2;
            end
            ST_FSEARCH: begin
                if (CW'(r_i) < r_count) begin
                    if (r_hdr >= rd_start && r_hdr < rd_end) begin
                        if (!tk_a) begin
                            n_status = STS_BADPTR;
                            n_state  = ST_DONE;
                        end else begin
                            n_fs      = rd_start;
                            n_old_end = rd_end;
                            n_state   = ST_FCHECK;
                        end
                    end else if (r_i == IW'(MAX_FRAGMENTS - 1)) begin
                        n_status = STS_BADPTR;
                        n_state  = ST_DONE;
                    end else begin
                        n_i = i_nxt;
                    end
                end else begin
                    n_status = STS_BADPTR;
                    n_state  = ST_DONE;
                end
            end
            ST_FCHECK: begin
                n_fe   = fe;
                n_tail = tail;
                if (slots_tot >= (CW+1)'(MAX_FRAGMENTS)) begin
                    n_status = STS_FULL;
                    n_state  = ST_DONE;
                end else if (head) begin
                    n_state = ST_FHEAD;
                end else if (tail) begin
                    n_state = ST_FTAIL;
                end else begin
                    n_state = ST_FCLR;
                end
            end
            ST_FHEAD: begin
                op_wa_end = 1'b1;
                wa_end    = r_hdr[ADDR_BITS-1:0];
                op_wb     = 1'b1;
                wb_start  = r_hdr[ADDR_BITS-1:0];
                wb_end    = r_old_end[ADDR_BITS-1:0];
                op_up     = 1'b1;
                n_count   = r_count + CW'(1);
                n_i       = i_nxt;
                n_state   = r_tail ? ST_FTAIL : ST_FCLR;
            end
            ST_FTAIL: begin
                op_wa_end = 1'b1;
                wa_end    = r_fe[ADDR_BITS-1:0];
                op_wb     = 1'b1;
                wb_start  = r_fe[ADDR_BITS-1:0];
                wb_end    = r_old_end[ADDR_BITS-1:0];
                op_up     = 1'b1;
                n_count   = r_count + CW'(1);
                n_state   = ST_FCLR;
            end
            ST_FCLR: begin
                op_wa_taken = 1'b1;
                wa_taken    = 1'b0;
                n_status    = STS_DONE;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                o_rsp_valid = 1'b1;
                if (!i_rsp_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int k = 1; k < MAX_FRAGMENTS; k++) begin
            if (op_up && k > int'(r_i) + 1) begin
                r_start[k] <= r_start[k-1];
                r_end[k]   <= r_end[k-1];
                r_taken[k] <= r_taken[k-1];
            end
        end
        for (int k = 0; k < MAX_FRAGMENTS - 1; k++) begin
            if (op_dn && k > int'(r_i)) begin
                r_start[k] <= r_start[k+1];
                r_end[k]   <= r_end[k+1];
                r_taken[k] <= r_taken[k+1];
            end
        end
        for (int k = 0; k < MAX_FRAGMENTS; k++) begin
            if (k == int'(r_i)) begin
                if (op_wa_start) begin
                    r_start[k] <= wa_start;
                end
                if (op_wa_end) begin
                    r_end[k] <= wa_end;
                end
                if (op_wa_taken) begin
                    r_taken[k] <= wa_taken;
                end
            end
            if (op_wb && k == int'(r_i) + 1) begin
                r_start[k] <= wb_start;
                r_end[k]   <= wb_end;
                r_taken[k] <= wb_taken;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_need    <= n_need;
        r_hdr     <= n_hdr;
        r_base    <= n_base;
        r_fs      <= n_fs;
        r_old_end <= n_old_end;
        r_fe      <= n_fe;
        r_tail    <= n_tail;
        r_status  <= n_status;
        r_uaddr   <= n_uaddr;
        r_i       <= n_i;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/core/fragment_table_allocator.sv =====
// Fragment table allocator top level: register port, queues, front and back ends
//
// Requests enter through a queue-style port (push/full) with kind, request_bytes
// and address; answers leave through a queue-style port (empty/pop) with
// kind_echo, status and user_address, one answer per request, in order.
// heap_base and heap_limit sit on an APB port at byte addresses 0 and 4;
// write them only while no request is in flight.
// A two-entry queue separates the front end from the table sequencer, and a
// two-entry queue holds finished answers, so requests keep entering while an
// answer waits to be popped; when both queues fill, full rises and holds.
// The sequencer touches one table entry per cycle. An allocate runs a merge
// pass, a search, a take or an append with its table write, and a second
// merge pass; a free runs a search, a check, an optional head split and tail
// split, and a clear. Each answer waits in the done state until the answer queue has room.
// Reset empties the table and both queues and restores heap_base to zero and
// heap_limit to all ones; no clearing pass is needed.
module fragment_table_allocator #(
    parameter int MAX_FRAGMENTS = fta_pkg::DEF_MAX_FRAGMENTS,
    parameter int HEADER_BYTES  = fta_pkg::DEF_HEADER_BYTES,
    parameter int ADDR_BITS     = fta_pkg::DEF_ADDR_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_kind,
    input  logic [23:0] i_request_bytes,
    input  logic [31:0] i_address,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind_echo,
    output logic [1:0]  o_status,
    output logic [31:0] o_user_address,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fta_pkg::*;

    `include "fragment_table_allocator_defines.svh"

    localparam int SW = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 2;
    localparam int QW = 2 + 2 * SW;

    logic [31:0]   r_heap_base, r_heap_limit;
    logic          cfg_wr;
    logic [SW-1:0] f_need, f_hdr, q_need, q_hdr;
    logic          f_bad, q_bad, q_kind, q_empty, req_pop;
    t_rsp          rsp, out_rsp;
    logic          rsp_valid, out_full;
    logic [RSP_W-1:0] out_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_HEAP_LIMIT) ? r_heap_limit : r_heap_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= '0;
            r_heap_limit <= '1;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_HEAP_BASE) begin
                r_heap_base <= pwdata;
            end else begin
                r_heap_limit <= pwdata;
            end
        end
    end

    fta_front #(
        .HEADER_BYTES (HEADER_BYTES),
        .ADDR_BITS    (ADDR_BITS)
    ) u_front (
        .i_request_bytes (i_request_bytes),
        .i_address       (i_address),
        .o_need          (f_need),
        .o_hdr           (f_hdr),
        .o_bad           (f_bad)
    );

    fta_queue #(
        .WIDTH (QW)
    ) u_req_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({i_kind, f_bad, f_need, f_hdr}),
        .o_full  (full),
        .i_pop   (req_pop),
        .o_rdata ({q_kind, q_bad, q_need, q_hdr}),
        .o_empty (q_empty)
    );

    fta_back #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS),
        .HEADER_BYTES  (HEADER_BYTES),
        .ADDR_BITS     (ADDR_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_heap_base  (r_heap_base),
        .i_heap_limit (r_heap_limit),
        .i_req_valid  (!q_empty),
        .i_req_kind   (q_kind),
        .i_req_bad    (q_bad),
        .i_req_need   (q_need),
        .i_req_hdr    (q_hdr),
        .o_req_pop    (req_pop),
        .o_rsp        (rsp),
        .o_rsp_valid  (rsp_valid),
        .i_rsp_full   (out_full)
    );

    fta_queue #(
        .WIDTH (RSP_W)
    ) u_rsp_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rsp_valid),
        .i_wdata (rsp),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_rdata (out_rdata),
        .o_empty (empty)
    );

    assign out_rsp        = t_rsp'(out_rdata);
    assign o_kind_echo    = out_rsp.kind;
    assign o_status       = out_rsp.status;
    assign o_user_address = out_rsp.user_address;

    `FTA_ASSERT_IMPL(a_free_no_addr, i_clk, i_rst_n, rsp_valid && rsp.kind == KIND_FREE, rsp.user_address == '0)
    `FTA_ASSERT_IMPL(a_refused_no_addr, i_clk, i_rst_n, rsp_valid && rsp.status != STS_DONE, rsp.user_address == '0)
    `FTA_ASSERT_IMPL(a_pop_not_done, i_clk, i_rst_n, req_pop, !rsp_valid)

endmodule

// ===== verif/fta_checker.sv =====
// Checker for the fragment table allocator: watches requests and answers, predicts, compares
`timescale 1ns / 100ps
module fta_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        i_kind,
    input  logic [23:0] i_request_bytes,
    input  logic [31:0] i_address,
    input  logic        empty,
    input  logic        pop,
    input  logic        i_kind_echo,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_user_address,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_errors,
    output int          o_pending
);
    import fta_pkg::*;

    localparam int          MAXF  = DEF_MAX_FRAGMENTS;
    localparam logic [63:0] HDR   = 64'(DEF_HEADER_BYTES);
    localparam logic [63:0] AMASK = 64'hFFFF_FFFF;

    typedef struct {
        logic        kind;
        t_status     status;
        logic [31:0] uaddr;
    } t_answer;

    logic [63:0] seg_lo [MAXF];
    logic [63:0] seg_hi [MAXF];
    bit          seg_used [MAXF];
    int          seg_cnt;
    logic [63:0] heap_base;
    logic [63:0] heap_limit;
    t_answer     answers_due [$];

    function automatic void open_slot(int p);
        for (int k = seg_cnt; k > p; k--) begin
            seg_lo[k]   = seg_lo[k-1];
            seg_hi[k]   = seg_hi[k-1];
            seg_used[k] = seg_used[k-1];
        end
    endfunction

    function automatic void coalesce();
        int i;
        i = 1;
        while (i < seg_cnt) begin
            if (seg_used[i] == seg_used[i-1]) begin
                seg_hi[i-1] = seg_hi[i];
                for (int k = i; k + 1 < seg_cnt; k++) begin
                    seg_lo[k]   = seg_lo[k+1];
                    seg_hi[k]   = seg_hi[k+1];
                    seg_used[k] = seg_used[k+1];
                end
                seg_cnt--;
            end else begin
                i++;
            end
        end
    endfunction

    function automatic t_status allocate(logic [63:0] bytes, output logic [31:0] uaddr);
        logic [63:0] need;
        logic [63:0] b;
        int          i;
        need  = bytes + HDR;
        uaddr = '0;
        if (seg_cnt >= MAXF) return STS_FULL;
        coalesce();
        for (i = 0; i < seg_cnt; i++)
            if (!seg_used[i] && seg_hi[i] - seg_lo[i] >= need) break;
        if (i < seg_cnt) begin
            b = seg_lo[i];
            seg_used[i] = 1'b1;
            if (seg_hi[i] - b > need) begin
                open_slot(i + 1);
                seg_lo[i+1]   = b + need;
                seg_hi[i+1]   = seg_hi[i];
                seg_used[i+1] = 1'b0;
                seg_hi[i]     = b + need;
                seg_cnt++;
            end
            coalesce();
        end else begin
            b = (seg_cnt > 0) ? seg_hi[seg_cnt-1] : heap_base;
            if (b > AMASK || need > AMASK - b || b + need > heap_limit) return STS_LIMIT;
            seg_lo[i]   = b;
            seg_hi[i]   = b + need;
            seg_used[i] = 1'b1;
            seg_cnt++;
            coalesce();
        end
        uaddr = 32'(b + HDR);
        return STS_DONE;
    endfunction

    function automatic t_status release_ptr(logic [63:0] bytes, logic [63:0] addr);
        logic [63:0] hdr;
        logic [63:0] cut;
        logic [63:0] old_hi;
        int          i;
        int          slots;
        bit          head;
        bit          tail;
        if (addr == 0 || addr < HDR) return STS_BADPTR;
        hdr = addr - HDR;
        for (i = 0; i < seg_cnt; i++)
            if (hdr >= seg_lo[i] && hdr < seg_hi[i]) break;
        if (i >= seg_cnt || !seg_used[i]) return STS_BADPTR;
        old_hi = seg_hi[i];
        cut    = (bytes + HDR >= old_hi - hdr) ? old_hi : hdr + HDR + bytes;
        head   = hdr > seg_lo[i];
        tail   = cut < old_hi;
        slots  = int'(head) + int'(tail);
        if (seg_cnt + slots >= MAXF) return STS_FULL;
        if (head) begin
            open_slot(i);
            seg_hi[i]   = hdr;
            seg_lo[i+1] = hdr;
            seg_cnt++;
            i++;
        end
        if (tail) begin
            open_slot(i + 1);
            seg_lo[i+1]   = cut;
            seg_hi[i+1]   = old_hi;
            seg_used[i+1] = 1'b1;
            seg_hi[i]     = cut;
            seg_cnt++;
        end
        seg_used[i] = 1'b0;
        return STS_DONE;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_answer a;
        t_answer w;
        if (!i_rst_n) begin
            seg_cnt    = 0;
            heap_base  = '0;
            heap_limit = AMASK;
            answers_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_HEAP_BASE) heap_base = {32'd0, pwdata};
                else                           heap_limit = {32'd0, pwdata};
            end
            if (push && !full) begin
                a.kind = i_kind;
                if (i_kind == KIND_ALLOC) begin
                    a.status = allocate({40'd0, i_request_bytes}, a.uaddr);
                end else begin
                    a.status = release_ptr({40'd0, i_request_bytes}, {32'd0, i_address});
                    a.uaddr  = '0;
                end
                answers_due.push_back(a);
            end
            if (pop && !empty) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: answer with no request outstanding", $time);
                    o_errors++;
                end else begin
                    w = answers_due.pop_front();
                    if (i_kind_echo !== w.kind) report_mismatch("kind_echo", i_kind_echo, w.kind);
                    if (i_status !== w.status) report_mismatch("status", i_status, w.status);
                    if (i_user_address !== w.uaddr)
                        report_mismatch("user_address", i_user_address, w.uaddr);
                end
            end
        end
        o_pending = answers_due.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end
endmodule

// ===== verif/testbench.sv =====
// Testbench top for the fragment table allocator: stimulus, register setup and verdict
`timescale 1ns / 100ps
module testbench;
    import fta_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_kind;
    logic [23:0] i_request_bytes;
    logic [31:0] i_address;
    logic        empty;
    logic        pop;
    logic        o_kind_echo;
    logic [1:0]  o_status;
    logic [31:0] o_user_address;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;

    bit          calm;
    bit          send_idle;
    int          pop_hold;
    logic [31:0] ptr_pool [$];
    int          status_seen [4];
    int          frees_sent;

    fragment_table_allocator dut (.*);

    fta_checker u_checker (
        .i_clk, .i_rst_n, .push, .full, .i_kind, .i_request_bytes, .i_address,
        .empty, .pop, .i_kind_echo(o_kind_echo), .i_status(o_status),
        .i_user_address(o_user_address), .psel, .penable, .pwrite, .pready,
        .paddr, .pwdata, .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // answer side: random stalls, plus a long hold-off on request
    initial begin
        int idle_left;
        idle_left = 0;
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (pop_hold > 0) begin
                pop_hold--;
                pop <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                idle_left = $urandom_range(0, 5);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            status_seen[o_status]++;
            if (o_kind_echo == KIND_ALLOC && o_status == STS_DONE) begin
                ptr_pool.push_back(o_user_address);
                if (ptr_pool.size() > 48) void'(ptr_pool.pop_front());
            end
        end
    end

    task automatic send(logic kind, logic [23:0] bytes, logic [31:0] addr);
        int gap;
        if (send_idle && !calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push            <= 1'b1;
        i_kind          <= kind;
        i_request_bytes <= bytes;
        i_address       <= addr;
        if (kind == KIND_FREE) frees_sent++;
        @(negedge i_clk);
        while (full) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic reg_write(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_request();
        logic [23:0] bytes;
        logic [31:0] addr;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 3)       bytes = 24'($urandom);
        else if (r < 10) bytes = 24'($urandom_range(0, 4095));
        else             bytes = 24'($urandom_range(0, 96));
        r = $urandom_range(0, 99);
        if (r < 50) begin
            send(KIND_ALLOC, bytes, 32'($urandom));
        end else if (r < 90 && ptr_pool.size() > 0) begin
            addr = ptr_pool[$urandom_range(0, ptr_pool.size() - 1)];
            if ($urandom_range(0, 2) == 0) addr = addr + 32'($urandom_range(0, 64));
            send(KIND_FREE, bytes, addr);
        end else if (r < 95) begin
            send(KIND_FREE, bytes, 32'($urandom));
        end else begin
            send(KIND_FREE, bytes, 32'($urandom_range(0, 16)));
        end
    endtask

    initial begin
        logic [31:0] big_ptr;
        calm            = 1'b0;
        send_idle       = 1'b1;
        pop_hold        = 0;
        frees_sent      = 0;
        status_seen     = '{default: 0};
        i_rst_n         = 1'b0;
        push            = 1'b0;
        i_kind          = KIND_ALLOC;
        i_request_bytes = '0;
        i_address       = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty heap at the top of the address space, and a zero limit
        reg_write(REG_HEAP_BASE, 32'hFFFF_FFFF);
        reg_write(REG_HEAP_LIMIT, 32'h0);
        send(KIND_ALLOC, 24'd0, 32'hFFFF_FFFF);
        settle();
        reg_write(REG_HEAP_BASE, 32'h0);
        send(KIND_ALLOC, 24'd0, 32'h0);
        send(KIND_FREE, 24'd0, 32'd8);
        settle();
        reg_write(REG_HEAP_BASE, 32'h40);
        reg_write(REG_HEAP_LIMIT, 32'hFFFF_FFFF);

        send(KIND_ALLOC, 24'd0, 32'h0);
        send(KIND_ALLOC, 24'hFF_FFFF, 32'h0);
        send(KIND_ALLOC, 24'd16, 32'hFFFF_FFFF);
        big_ptr = 32'h50;
        send(KIND_FREE, 24'd0, 32'd0);
        send(KIND_FREE, 24'd0, 32'd3);
        send(KIND_FREE, 24'd0, 32'd7);
        send(KIND_FREE, 24'hFF_FFFF, 32'hFFFF_FFFF);
        send(KIND_FREE, 24'd0, 32'h48);
        send(KIND_FREE, 24'd0, 32'h48);
        send(KIND_FREE, 24'h10, big_ptr + 32'h100);
        send(KIND_FREE, 24'hFF_FFFF, big_ptr + 32'h8000);
        send(KIND_FREE, 24'd4, big_ptr + 32'h0F_FFFF);
        send(KIND_ALLOC, 24'd4, 32'h0);
        send(KIND_ALLOC, 24'h20, 32'h0);
        send(KIND_FREE, 24'd8, 32'h48 + 32'h100_0007 + 32'h8);
        send(KIND_ALLOC, 24'd0, 32'h0);
        settle();

        repeat (600) random_request();
        pop_hold = 400;
        repeat (60) random_request();
        settle();

        reg_write(REG_HEAP_LIMIT, 32'h0200_8000);
        repeat (500) random_request();
        settle();

        reg_write(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
        reg_write(REG_HEAP_BASE, 32'h1234_5678);
        repeat (400) random_request();
        calm = 1'b1;
        repeat (240) random_request();
        settle();

        $display("Sent %0d frees among all requests; answers done %0d, table full %0d,",
                 frees_sent, status_seen[STS_DONE], status_seen[STS_FULL]);
        $display("bad pointer %0d, beyond limit %0d", status_seen[STS_BADPTR],
                 status_seen[STS_LIMIT]);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
